// ===== src/tws_pkg.sv =====
// Shared types and codes for the timer wheel scheduler.
`default_nettype none

package tws_pkg;

  localparam logic [1:0] OpTick   = 2'd0;
  localparam logic [1:0] OpArm    = 2'd1;
  localparam logic [1:0] OpCancel = 2'd2;

  localparam logic [1:0] KindAck   = 2'd0;
  localparam logic [1:0] KindFired = 2'd1;
  localparam logic [1:0] KindLate  = 2'd2;

  // The expiry is reduced modulo the bucket count one nibble per cycle.
  localparam int unsigned ExpW   = 32;
  localparam int unsigned DigW   = 4;
  localparam int unsigned NumDig = ExpW / DigW;

  typedef struct packed {
    logic [1:0]  operation;
    logic [3:0]  timer_id;
    logic [15:0] delay;
  } tws_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  fired_id;
    logic [31:0] uptime_now;
    logic        last;
  } tws_out_t;

endpackage

`default_nettype wire

// ===== src/timer_wheel_scheduler.sv =====
// Hashed timing wheel: slot storage, modulo sequencer and bucket scan.
`default_nettype none

// An item is taken when start is high and busy is low. A cancel or an unknown
// operation is never busy and gives its single result on the next cycle. An
// arm is busy while compare-subtract steps reduce the 32-bit expiry modulo
// NUM_BUCKETS a nibble per cycle. A tick is busy while the slot memory is read
// one slot per cycle and each slot goes through one 32-bit compare unit. The
// results of a tick come out one per strobe while the scan runs, the final one
// flagged by last, and the receiver has to take every strobe as it comes.
module timer_wheel_scheduler #(
  parameter int unsigned NUM_BUCKETS = 5,
  parameter int unsigned NUM_SLOTS   = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire tws_pkg::tws_in_t req_i,
  output logic                  res_valid_o,
  output tws_pkg::tws_out_t     res_o
);

  localparam int unsigned SlotW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned CntW  = $clog2(NUM_SLOTS + 1);
  localparam int unsigned BktW  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int unsigned ModW  = BktW + 1;
  localparam int unsigned DcntW = $clog2(tws_pkg::NumDig);

  localparam logic [ModW-1:0]  NbC      = ModW'(NUM_BUCKETS);
  localparam logic [BktW-1:0]  WpLast   = BktW'(NUM_BUCKETS - 1);
  localparam logic [CntW-1:0]  SlotEnd  = CntW'(NUM_SLOTS);
  localparam logic [DcntW-1:0] DigLast  = DcntW'(tws_pkg::NumDig - 1);

  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SMod  = 2'd1;
  localparam logic [1:0] SScan = 2'd2;

  logic [1:0] state_q, state_d;

  // Slot storage.
  logic [NUM_SLOTS-1:0] pending_q, pending_d;
  logic [31:0]          exp_mem [NUM_SLOTS];
  logic [BktW-1:0]      bkt_mem [NUM_SLOTS];
  logic [31:0]          exp_rd_q;
  logic [BktW-1:0]      bkt_rd_q;

  logic [BktW-1:0] wp_q, wp_d;
  logic [31:0]     tick_q, tick_d;

  // Arm sequencer.
  logic [31:0]      mod_val_q, mod_val_d;
  logic [BktW-1:0]  mod_r_q, mod_r_d;
  logic [DcntW-1:0] dig_q, dig_d;
  logic [3:0]       id_q, id_d;
  logic             id_ok;

  // Scan sequencer.
  logic [CntW-1:0]  rd_cnt_q, rd_cnt_d;
  logic             chk_vld_q, chk_vld_d;
  logic [SlotW-1:0] chk_idx_q, chk_idx_d;
  logic             held_vld_q, held_vld_d;
  logic [1:0]       held_kind_q, held_kind_d;
  logic [3:0]       held_id_q, held_id_d;

  logic [32:0] cmp_diff;
  logic        cmp_eq, cmp_lt, hit;

  logic                  res_valid_d;
  tws_pkg::tws_out_t     res_q, res_d;
  logic                  res_valid_q;

  logic             accept;
  logic [31:0]      arm_exp;
  logic             exp_we, bkt_we;
  logic [SlotW-1:0] wr_idx, rd_idx;

  assign accept  = start && (state_q == SIdle);
  assign arm_exp = tick_q + 32'(req_i.delay);
  assign id_ok   = (32'(req_i.timer_id) < NUM_SLOTS);
  assign rd_idx  = rd_cnt_q[SlotW-1:0];

  // Shared compare unit: one 33-bit subtract gives equal and below.
  assign cmp_diff = {1'b0, exp_rd_q} - {1'b0, tick_q};
  assign cmp_eq   = (cmp_diff == 33'd0);
  assign cmp_lt   = cmp_diff[32];
  assign hit      = chk_vld_q && pending_q[chk_idx_q] && (bkt_rd_q == wp_q)
                    && (cmp_eq || cmp_lt);

  // Four restoring steps of (2r + bit) mod NUM_BUCKETS per cycle.
  always_comb begin
    logic [ModW-1:0] t;
    logic [BktW-1:0] r;
    r = mod_r_q;
    for (int i = 0; i < tws_pkg::DigW; i++) begin
      t = {r, mod_val_q[31 - i]};
      if (t >= NbC) begin
        t = t - NbC;
      end
      r = t[BktW-1:0];
    end
    mod_r_d = r;
  end

  always_comb begin
    state_d     = state_q;
    pending_d   = pending_q;
    wp_d        = wp_q;
    tick_d      = tick_q;
    mod_val_d   = mod_val_q;
    dig_d       = dig_q;
    id_d        = id_q;
    rd_cnt_d    = rd_cnt_q;
    chk_vld_d   = 1'b0;
    chk_idx_d   = rd_idx;
    held_vld_d  = held_vld_q;
    held_kind_d = held_kind_q;
    held_id_d   = held_id_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    exp_we      = 1'b0;
    bkt_we      = 1'b0;
    wr_idx      = SlotW'(id_q);

    case (state_q)
      SIdle: begin
        if (accept) begin
          case (req_i.operation)
            tws_pkg::OpArm: begin
              exp_we    = id_ok;
              wr_idx    = SlotW'(req_i.timer_id);
              mod_val_d = arm_exp;
              dig_d     = '0;
              id_d      = req_i.timer_id;
              state_d   = SMod;
            end
            tws_pkg::OpCancel: begin
              if (id_ok) begin
                pending_d[SlotW'(req_i.timer_id)] = 1'b0;
              end
              res_valid_d = 1'b1;
              res_d       = '{kind: tws_pkg::KindAck, fired_id: req_i.timer_id,
                              uptime_now: tick_q, last: 1'b1};
            end
            tws_pkg::OpTick: begin
              wp_d       = (wp_q == WpLast) ? '0 : wp_q + 1'b1;
              tick_d     = tick_q + 32'd1;
              rd_cnt_d   = '0;
              held_vld_d = 1'b0;
              state_d    = SScan;
            end
            default: begin
              res_valid_d = 1'b1;
              res_d       = '{kind: tws_pkg::KindAck, fired_id: 4'd0,
                              uptime_now: tick_q, last: 1'b1};
            end
          endcase
        end
      end

      SMod: begin
        mod_val_d = mod_val_q << tws_pkg::DigW;
        dig_d     = dig_q + 1'b1;
        if (dig_q == DigLast) begin
          bkt_we = (32'(id_q) < NUM_SLOTS);
          if (bkt_we) begin
            pending_d[SlotW'(id_q)] = 1'b1;
          end
          res_valid_d = 1'b1;
          res_d       = '{kind: tws_pkg::KindAck, fired_id: id_q,
                          uptime_now: tick_q, last: 1'b1};
          state_d     = SIdle;
        end
      end

      SScan: begin
        if (rd_cnt_q != SlotEnd) begin
          rd_cnt_d  = rd_cnt_q + 1'b1;
          chk_vld_d = 1'b1;
        end
        if (hit) begin
          pending_d[chk_idx_q] = 1'b0;
          // The previous hit is now known not to be the final result.
          if (held_vld_q) begin
            res_valid_d = 1'b1;
            res_d       = '{kind: held_kind_q, fired_id: held_id_q,
                            uptime_now: tick_q, last: 1'b0};
          end
          held_vld_d  = 1'b1;
          held_kind_d = cmp_eq ? tws_pkg::KindFired : tws_pkg::KindLate;
          held_id_d   = 4'(chk_idx_q);
        end
        if ((rd_cnt_q == SlotEnd) && !chk_vld_q) begin
          res_valid_d = 1'b1;
          if (held_vld_q) begin
            res_d = '{kind: held_kind_q, fired_id: held_id_q,
                      uptime_now: tick_q, last: 1'b1};
          end else begin
            res_d = '{kind: tws_pkg::KindAck, fired_id: 4'd0,
                      uptime_now: tick_q, last: 1'b1};
          end
          state_d = SIdle;
        end
      end

      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      pending_q   <= '0;
      wp_q        <= '0;
      tick_q      <= '0;
      dig_q       <= '0;
      rd_cnt_q    <= '0;
      chk_vld_q   <= 1'b0;
      held_vld_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pending_q   <= pending_d;
      wp_q        <= wp_d;
      tick_q      <= tick_d;
      dig_q       <= dig_d;
      rd_cnt_q    <= rd_cnt_d;
      chk_vld_q   <= chk_vld_d;
      held_vld_q  <= held_vld_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mod_val_q   <= mod_val_d;
    mod_r_q     <= (state_q == SMod) ? mod_r_d : '0;
    id_q        <= id_d;
    chk_idx_q   <= chk_idx_d;
    held_kind_q <= held_kind_d;
    held_id_q   <= held_id_d;
    res_q       <= res_d;
  end

  // Slot memories: one write port and one registered read port each.
  always_ff @(posedge clk_i) begin
    if (exp_we) begin
      exp_mem[wr_idx] <= arm_exp;
    end
    exp_rd_q <= exp_mem[rd_idx];
  end

  always_ff @(posedge clk_i) begin
    if (bkt_we) begin
      bkt_mem[wr_idx] <= mod_r_d;
    end
    bkt_rd_q <= bkt_mem[rd_idx];
  end

  assign busy        = (state_q != SIdle);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

`ifndef NO_ASSERTIONS
  a_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy && !start |=> !busy)
    else $error("block left idle without a transfer");

  a_cancel_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && req_i.operation == tws_pkg::OpCancel
    |=> res_valid_o && res_o.last && !busy)
    else $error("cancel did not give one final result");

  a_tick_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && req_i.operation == tws_pkg::OpTick
    |=> tick_q == $past(tick_q) + 32'd1 && busy)
    else $error("tick did not advance uptime");

  a_more_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.last |-> busy)
    else $error("non-final result while idle");

  a_wheel_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wp_q <= WpLast)
    else $error("wheel position out of range");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the timer wheel scheduler.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NUM_BUCKETS  = 5;
  localparam int unsigned NUM_SLOTS    = 16;
  localparam int          STALL_LIMIT  = 3000;
  localparam int          DRAIN_CYCLES = 40;

  // Operation code that the block treats as unknown.
  localparam logic [1:0] OpUnused = 2'd3;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  tws_pkg::tws_in_t  req_i = '0;
  logic              res_valid_o;
  tws_pkg::tws_out_t res_o;

  timer_wheel_scheduler #(
    .NUM_BUCKETS(NUM_BUCKETS),
    .NUM_SLOTS  (NUM_SLOTS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Shadow copy of the wheel.
  logic        slot_armed  [NUM_SLOTS];
  logic [31:0] slot_due    [NUM_SLOTS];
  logic [2:0]  slot_wheel  [NUM_SLOTS];
  logic [2:0]  wheel_pos;
  logic [31:0] uptime;

  tws_pkg::tws_in_t  cmd_q[$];
  tws_pkg::tws_out_t timer_events_q[$];
  tws_pkg::tws_out_t want_ev;
  int                sent_cnt = 0;
  int                fail_cnt = 0;
  int                quiet_cycles = 0;

  function automatic tws_pkg::tws_out_t timer_event(logic [1:0] kind, logic [3:0] id,
                                                    logic [31:0] now, logic fin);
    tws_pkg::tws_out_t ev;
    ev.kind       = kind;
    ev.fired_id   = id;
    ev.uptime_now = now;
    ev.last       = fin;
    return ev;
  endfunction

  // Applies one transferred item to the shadow wheel and queues the events it causes.
  task automatic wheel_step(input tws_pkg::tws_in_t it);
    tws_pkg::tws_out_t hits[$];
    tws_pkg::tws_out_t ev;
    case (it.operation)
      tws_pkg::OpArm: begin
        slot_due[it.timer_id]   = uptime + 32'(it.delay);
        slot_wheel[it.timer_id] = 3'(slot_due[it.timer_id] % 32'(NUM_BUCKETS));
        slot_armed[it.timer_id] = 1'b1;
        timer_events_q.push_back(timer_event(tws_pkg::KindAck, it.timer_id, uptime, 1'b1));
      end
      tws_pkg::OpCancel: begin
        slot_armed[it.timer_id] = 1'b0;
        timer_events_q.push_back(timer_event(tws_pkg::KindAck, it.timer_id, uptime, 1'b1));
      end
      tws_pkg::OpTick: begin
        wheel_pos = (wheel_pos == 3'(NUM_BUCKETS - 1)) ? 3'd0 : wheel_pos + 3'd1;
        uptime    = uptime + 32'd1;
        for (int s = 0; s < NUM_SLOTS; s++) begin
          if (slot_armed[s] && slot_wheel[s] == wheel_pos) begin
            if (slot_due[s] == uptime) begin
              slot_armed[s] = 1'b0;
              hits.push_back(timer_event(tws_pkg::KindFired, 4'(s), uptime, 1'b0));
            end else if (slot_due[s] < uptime) begin
              slot_armed[s] = 1'b0;
              hits.push_back(timer_event(tws_pkg::KindLate, 4'(s), uptime, 1'b0));
            end
          end
        end
        if (hits.size() == 0) begin
          timer_events_q.push_back(timer_event(tws_pkg::KindAck, 4'd0, uptime, 1'b1));
        end
        foreach (hits[i]) begin
          ev = hits[i];
          ev.last = (i == hits.size() - 1);
          timer_events_q.push_back(ev);
        end
      end
      default: begin
        timer_events_q.push_back(timer_event(tws_pkg::KindAck, 4'd0, uptime, 1'b1));
      end
    endcase
  endtask

  // Driver: holds an item until busy drops, then loads the next one or idles.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      req_i <= '0;
    end else begin
      if (start && !busy) begin
        wheel_step(req_i);
      end
      if (!start || !busy) begin
        if (cmd_q.size() != 0 &&
            !($urandom_range(0, 99) < 14 && !(sent_cnt >= 70 && sent_cnt < 120))) begin
          start <= 1'b1;
          req_i <= cmd_q.pop_front();
          sent_cnt++;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobe is a transfer that must match the oldest queued event.
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      if (timer_events_q.size() == 0) begin
        $display("%0t: unexpected result kind=%0d id=%0d uptime=%0d last=%0b", $time,
                 res_o.kind, res_o.fired_id, res_o.uptime_now, res_o.last);
        fail_cnt++;
      end else begin
        want_ev = timer_events_q.pop_front();
        if (want_ev.kind !== res_o.kind || want_ev.fired_id !== res_o.fired_id ||
            want_ev.uptime_now !== res_o.uptime_now || want_ev.last !== res_o.last) begin
          $display("%0t: mismatch expected kind=%0d id=%0d uptime=%0d last=%0b", $time,
                   want_ev.kind, want_ev.fired_id, want_ev.uptime_now, want_ev.last);
          $display("%0t:          actual   kind=%0d id=%0d uptime=%0d last=%0b", $time,
                   res_o.kind, res_o.fired_id, res_o.uptime_now, res_o.last);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || res_valid_o) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic tws_pkg::tws_in_t make_cmd(logic [1:0] op, logic [3:0] id,
                                                logic [15:0] dly);
    tws_pkg::tws_in_t it;
    it.operation = op;
    it.timer_id  = id;
    it.delay     = dly;
    return it;
  endfunction

  initial begin
    int pick;
    logic [15:0] dly;
    for (int s = 0; s < NUM_SLOTS; s++) slot_armed[s] = 1'b0;
    wheel_pos = '0;
    uptime    = '0;

    // Directed: empty tick, unknown operation, cancel of an idle slot, then
    // every slot armed into one bucket so a single tick reports all that are due.
    cmd_q.push_back(make_cmd(tws_pkg::OpTick, 4'd0, 16'd0));
    cmd_q.push_back(make_cmd(OpUnused, 4'hF, 16'hFFFF));
    cmd_q.push_back(make_cmd(tws_pkg::OpCancel, 4'd0, 16'd0));
    for (int s = 0; s < NUM_SLOTS; s++) begin
      // Slot 0 is late (zero delay) and slot 15 lies far ahead in the same bucket.
      dly = (s == 0) ? 16'd0 : (s == NUM_SLOTS - 1) ? 16'hFFFF : 16'd5;
      cmd_q.push_back(make_cmd(tws_pkg::OpArm, 4'(s), dly));
    end
    cmd_q.push_back(make_cmd(tws_pkg::OpCancel, 4'd14, 16'd0));
    cmd_q.push_back(make_cmd(tws_pkg::OpArm, 4'd13, 16'd3));
    repeat (5) cmd_q.push_back(make_cmd(tws_pkg::OpTick, 4'($urandom), 16'($urandom)));

    // Random: mostly short delays so timers come due while the run lasts.
    repeat (155) begin
      pick = $urandom_range(0, 99);
      if (pick < 42) begin
        cmd_q.push_back(make_cmd(tws_pkg::OpTick, 4'($urandom), 16'($urandom)));
      end else if (pick < 80) begin
        dly = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 14));
        cmd_q.push_back(make_cmd(tws_pkg::OpArm, 4'($urandom), dly));
      end else if (pick < 96) begin
        cmd_q.push_back(make_cmd(tws_pkg::OpCancel, 4'($urandom), 16'($urandom)));
      end else begin
        cmd_q.push_back(make_cmd(OpUnused, 4'($urandom), 16'($urandom)));
      end
    end

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (cmd_q.size() != 0 || start || timer_events_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_cnt == 0 && timer_events_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
